/* hdl/wnpm_pkg.sv */
// ----------------------------------------------------------------------------
// wnpm_pkg
// Shared types and constants of the windowed node pattern matcher: opcodes,
// status codes and the command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package wnpm_pkg;

  // width of the node type and child count ports
  localparam int unsigned FieldW = 16;

  // command codes carried on the input channel
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TARGET = 2'd2,
    OP_END    = 2'd3
  } opcode_e;

  // outcome reported at end of target
  typedef enum logic [1:0] {
    ST_NO_MATCH = 2'd0,
    ST_MATCH    = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // decoded command word queued between front and back
  typedef struct packed {
    opcode_e             op;
    logic [FieldW-1:0]   node_type;
    logic [FieldW-1:0]   child_count;
  } cmd_t;

endpackage

/* hdl/wnpm_front.sv */
// ----------------------------------------------------------------------------
// wnpm_front
// Input side: takes words from the input channel, decodes the opcode and
// trims the element fields to the configured field width before queueing.
// ----------------------------------------------------------------------------
module wnpm_front #(
  parameter int unsigned FIELD_BITS = 16
) (
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [wnpm_pkg::FieldW-1:0] node_type_i,
  input  logic [wnpm_pkg::FieldW-1:0] child_count_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output wnpm_pkg::cmd_t             q_cmd_o
);
  import wnpm_pkg::*;

  // only the low field bits take part in the comparison
  localparam int unsigned EffW  = (FIELD_BITS < FieldW) ? FIELD_BITS : FieldW;
  localparam int unsigned Shift = FieldW - EffW;
  localparam logic [FieldW-1:0] FieldMask = {FieldW{1'b1}} >> Shift;

  // accept whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // decode and mask
  always_comb begin
    q_cmd_o.op          = opcode_e'(opcode_i);
    q_cmd_o.node_type   = node_type_i & FieldMask;
    q_cmd_o.child_count = child_count_i & FieldMask;
  end

endmodule

/* hdl/wnpm_fifo.sv */
// ----------------------------------------------------------------------------
// wnpm_fifo
// Two-entry command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module wnpm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wnpm_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output wnpm_pkg::cmd_t pop_cmd_o
);
  import wnpm_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // fill count stays in range and pointers agree with it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CntW'(Depth)) && ((cnt_q == CntW'(Depth)) || (cnt_q == '0)
      ? (wr_ptr_q == rd_ptr_q) : (wr_ptr_q != rd_ptr_q)))
    else $error("queue fill count and pointers disagree");

endmodule

/* hdl/wnpm_back.sv */
// ----------------------------------------------------------------------------
// wnpm_back
// Execution side: holds the pattern and the target window, compares every
// window position against the pattern in parallel and registers the status.
// ----------------------------------------------------------------------------
module wnpm_back #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned FIELD_BITS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  wnpm_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     status_o
);
  import wnpm_pkg::*;

  localparam int unsigned EffW = (FIELD_BITS < FieldW) ? FIELD_BITS : FieldW;
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);

  // pattern kept newest-first so position i lines up with window position i
  logic [EffW-1:0] pat_type_q [MAX_PATTERN];
  logic [EffW-1:0] pat_cnt_q  [MAX_PATTERN];
  // window, newest element at position 0
  logic [EffW-1:0] win_type_q [MAX_PATTERN];
  logic [EffW-1:0] win_cnt_q  [MAX_PATTERN];

  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] seen_q, seen_d, seen_inc;
  logic            ovf_q, ovf_d;
  logic            match_q, match_d;
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;

  logic [EffW-1:0]        e_type, e_cnt;
  logic [EffW-1:0]        cand_type [MAX_PATTERN];
  logic [EffW-1:0]        cand_cnt  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] pos_ok;
  logic                   window_hit;
  logic                   out_free;
  logic                   pop;
  logic                   do_append, do_target;

  assign e_type = q_cmd_i.node_type[EffW-1:0];
  assign e_cnt  = q_cmd_i.child_count[EffW-1:0];

  // output stage can take a status when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;
  assign pop      = q_valid_i && ((q_cmd_i.op != OP_END) || out_free);
  assign q_pop_o  = pop;

  assign do_append = pop && (q_cmd_i.op == OP_APPEND) && (len_q < MaxLen);
  assign do_target = pop && (q_cmd_i.op == OP_TARGET);

  // per-position compare against the window as it looks after the shift
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_pos
    if (g == 0) begin : g_head
      assign cand_type[g] = e_type;
      assign cand_cnt[g]  = e_cnt;
    end else begin : g_tail
      assign cand_type[g] = win_type_q[g-1];
      assign cand_cnt[g]  = win_cnt_q[g-1];
    end
    assign pos_ok[g] = (LenW'(g) >= len_q) ||
                       ((cand_type[g] == pat_type_q[g]) && (cand_cnt[g] >= pat_cnt_q[g]));
  end

  assign seen_inc   = (seen_q < MaxLen) ? seen_q + 1'b1 : seen_q;
  assign window_hit = (len_q != '0) && (seen_inc >= len_q) && (&pos_ok);

  // control state update per command
  always_comb begin
    len_d       = len_q;
    ovf_d       = ovf_q;
    seen_d      = seen_q;
    match_d     = match_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop) begin
      unique case (q_cmd_i.op)
        OP_CLEAR: begin
          len_d = '0;
          ovf_d = 1'b0;
        end
        OP_APPEND: begin
          if (len_q < MaxLen) begin
            len_d = len_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        OP_TARGET: begin
          seen_d  = seen_inc;
          match_d = match_q || window_hit;
        end
        OP_END: begin
          priority if ((len_q == '0) || (seen_q == '0)) begin
            status_d = ST_EMPTY;
          end else if (ovf_q) begin
            status_d = ST_OVERFLOW;
          end else if (match_q) begin
            status_d = ST_MATCH;
          end else begin
            status_d = ST_NO_MATCH;
          end
          out_valid_d = 1'b1;
          seen_d      = '0;
          match_d     = 1'b0;
        end
        default: begin
          len_d = len_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      seen_q      <= '0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      seen_q      <= seen_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  // pattern and window shift registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (do_append) begin
      for (int i = 1; i < MAX_PATTERN; i++) begin
        pat_type_q[i] <= pat_type_q[i-1];
        pat_cnt_q[i]  <= pat_cnt_q[i-1];
      end
      pat_type_q[0] <= e_type;
      pat_cnt_q[0]  <= e_cnt;
    end
    if (do_target) begin
      for (int i = 1; i < MAX_PATTERN; i++) begin
        win_type_q[i] <= win_type_q[i-1];
        win_cnt_q[i]  <= win_cnt_q[i-1];
      end
      win_type_q[0] <= e_type;
      win_cnt_q[0]  <= e_cnt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  // counters never pass capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q <= MaxLen) && (seen_q <= MaxLen))
    else $error("pattern length or target count beyond capacity");

  // an end command never overwrites a status still waiting to be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (q_cmd_i.op == OP_END)) |-> !(out_valid_q && !out_ready_i))
    else $error("pending status overwritten");

  // end of target leaves the target side cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (q_cmd_i.op == OP_END)) |=> (seen_q == '0) && !match_q && out_valid_q)
    else $error("target side not cleared after end");

  // a match is only reported with a non-empty pattern and enough elements
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(match_q) |-> (len_q != '0) && (seen_q >= len_q))
    else $error("match flagged without a full window");

endmodule

/* hdl/windowed_node_pattern_matcher.sv */
// ----------------------------------------------------------------------------
// windowed_node_pattern_matcher
// Searches a stream of (node type, child count) elements for a contiguous run
// that matches a stored pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command word:
//   opcode_i selects clear pattern, append pattern element, target element or
//   end of target; node_type_i and child_count_i carry the element.
//   Output channel (out_valid_o / out_ready_i) carries one status word per
//   end-of-target command: no match, match, empty, or pattern overflow.
//   Throughput is one word per cycle for every opcode, except that an
//   end-of-target word waits while an earlier status is not yet taken; the
//   window shift and all MAX_PATTERN position compares run in parallel. An
//   end-of-target word passes the command queue, then the status register.
//   Words pass through a two-entry queue, so the input keeps flowing while a
//   status waits; if the receiver stalls, the back end holds further
//   end-of-target words, the queue fills and in_ready_o drops.
//   Reset empties the queue, clears pattern length, overflow flag, target
//   count and match flag; pattern contents are not cleared.
// ----------------------------------------------------------------------------
module windowed_node_pattern_matcher #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned FIELD_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [wnpm_pkg::FieldW-1:0] node_type_i,
  input  logic [wnpm_pkg::FieldW-1:0] child_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o
);
  import wnpm_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  cmd_t push_cmd, pop_cmd;

  // decode side
  wnpm_front #(
    .FIELD_BITS(FIELD_BITS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .node_type_i  (node_type_i),
    .child_count_i(child_count_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  // command queue
  wnpm_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_cmd_o (pop_cmd)
  );

  // execution side
  wnpm_back #(
    .MAX_PATTERN(MAX_PATTERN),
    .FIELD_BITS (FIELD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (pop_cmd),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o)
  );

endmodule
